[rtl/core/msd_pkg.sv]
// ----------------------------------------------------------------------------
// msd_pkg: shared types and codes of the mid/side band decision core
// Field widths, item codes and the queue entry that links front and back.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SMP_W    = 24;
    localparam int unsigned CNT_IN_W = 11;
    localparam int unsigned Q_DEPTH  = 4;

    localparam logic [1:0] OP_BAND   = 2'd0;
    localparam logic [1:0] OP_LINE   = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_BAND  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_SOME = 2'd1;
    localparam logic [1:0] SEL_ALL  = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        // comparison operands, zero thresholds already forced to one
        logic [WORD_W-1:0]       m;
        logic [WORD_W-1:0]       atl;
        logic [WORD_W-1:0]       atr;
        logic [WORD_W-1:0]       x;
        logic [WORD_W-1:0]       y;
        logic [WORD_W-1:0]       p;
        logic [WORD_W-1:0]       q;
        // raw band fields for the result, with the minimum threshold and half spread
        logic [WORD_W-1:0]       thr_l;
        logic [WORD_W-1:0]       thr_r;
        logic [WORD_W-1:0]       en_l;
        logic [WORD_W-1:0]       en_r;
        logic [WORD_W-1:0]       en_m;
        logic [WORD_W-1:0]       en_s;
        logic [WORD_W-1:0]       spr_l;
        logic [WORD_W-1:0]       spr_r;
        logic [WORD_W-1:0]       thr_min;
        logic [WORD_W-1:0]       spr_half;
        logic [CNT_IN_W-1:0]     cnt;
        logic signed [SMP_W-1:0] smp_l;
        logic signed [SMP_W-1:0] smp_r;
    } t_item;

endpackage

[rtl/core/mid_side_stereo_band_decision_core.sv]
// ----------------------------------------------------------------------------
// mid_side_stereo_band_decision_core: mid/side band decision and line matrix
// Front intake, request queue and back-end sequencer with output register.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  input    i_valid / o_ready   i_opcode, band fields, i_line_count, samples
//  output   o_valid / i_ready   o_kind, o_ms_used, band outputs, samples,
//                               o_ms_select
//
//  Line pairs and frame ends stream through the back end at one per cycle
//  while the output is not stalled. A band record holds the back end while
//  two shared 32x32 multipliers build its two 128-bit cross products. Lines
//  and frame ends pass the front register, queue and output register.
//  Reset is synchronous, active low, and clears the queue and all band state.
//  A stalled output holds its result while the four-entry queue keeps taking
//  requests until it is full.
// ----------------------------------------------------------------------------
module mid_side_stereo_band_decision_core #(
    parameter int MAX_BAND_LINES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [msd_pkg::WORD_W-1:0]       i_energy_left,
    input  logic [msd_pkg::WORD_W-1:0]       i_energy_right,
    input  logic [msd_pkg::WORD_W-1:0]       i_energy_mid,
    input  logic [msd_pkg::WORD_W-1:0]       i_energy_side,
    input  logic [msd_pkg::WORD_W-1:0]       i_thr_left,
    input  logic [msd_pkg::WORD_W-1:0]       i_thr_right,
    input  logic [msd_pkg::WORD_W-1:0]       i_spread_left,
    input  logic [msd_pkg::WORD_W-1:0]       i_spread_right,
    input  logic [msd_pkg::CNT_IN_W-1:0]     i_line_count,
    input  logic signed [msd_pkg::SMP_W-1:0] i_sample_left,
    input  logic signed [msd_pkg::SMP_W-1:0] i_sample_right,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_kind,
    output logic                             o_ms_used,
    output logic [msd_pkg::WORD_W-1:0]       o_out_thr_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_thr_right,
    output logic [msd_pkg::WORD_W-1:0]       o_out_energy_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_energy_right,
    output logic [msd_pkg::WORD_W-1:0]       o_out_spread_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_spread_right,
    output logic signed [msd_pkg::SMP_W-1:0] o_out_left,
    output logic signed [msd_pkg::SMP_W-1:0] o_out_right,
    output logic [1:0]                       o_ms_select
);
    import msd_pkg::*;

    t_item front_item;
    logic  front_valid;
    logic  front_ready;
    t_item head_item;
    logic  head_valid;
    logic  head_ready;

    msd_front #(
        .MAX_BAND_LINES (MAX_BAND_LINES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_energy_left  (i_energy_left),
        .i_energy_right (i_energy_right),
        .i_energy_mid   (i_energy_mid),
        .i_energy_side  (i_energy_side),
        .i_thr_left     (i_thr_left),
        .i_thr_right    (i_thr_right),
        .i_spread_left  (i_spread_left),
        .i_spread_right (i_spread_right),
        .i_line_count   (i_line_count),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .o_item_valid   (front_valid),
        .i_item_ready   (front_ready),
        .o_item         (front_item)
    );

    msd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (head_valid),
        .i_pop_ready  (head_ready),
        .o_pop_item   (head_item)
    );

    msd_back #(
        .MAX_BAND_LINES (MAX_BAND_LINES)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item_valid       (head_valid),
        .o_item_ready       (head_ready),
        .i_item             (head_item),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_ms_used          (o_ms_used),
        .o_out_thr_left     (o_out_thr_left),
        .o_out_thr_right    (o_out_thr_right),
        .o_out_energy_left  (o_out_energy_left),
        .o_out_energy_right (o_out_energy_right),
        .o_out_spread_left  (o_out_spread_left),
        .o_out_spread_right (o_out_spread_right),
        .o_out_left         (o_out_left),
        .o_out_right        (o_out_right),
        .o_ms_select        (o_ms_select)
    );

endmodule

[rtl/core/msd_front.sv]
// ----------------------------------------------------------------------------
// msd_front: request intake and classification
// Drops unused codes, prepares the comparison operands and clamps the count.
// ----------------------------------------------------------------------------
module msd_front #(
    parameter int MAX_BAND_LINES = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [msd_pkg::WORD_W-1:0]      i_energy_left,
    input  logic [msd_pkg::WORD_W-1:0]      i_energy_right,
    input  logic [msd_pkg::WORD_W-1:0]      i_energy_mid,
    input  logic [msd_pkg::WORD_W-1:0]      i_energy_side,
    input  logic [msd_pkg::WORD_W-1:0]      i_thr_left,
    input  logic [msd_pkg::WORD_W-1:0]      i_thr_right,
    input  logic [msd_pkg::WORD_W-1:0]      i_spread_left,
    input  logic [msd_pkg::WORD_W-1:0]      i_spread_right,
    input  logic [msd_pkg::CNT_IN_W-1:0]    i_line_count,
    input  logic signed [msd_pkg::SMP_W-1:0] i_sample_left,
    input  logic signed [msd_pkg::SMP_W-1:0] i_sample_right,
    output logic                            o_item_valid,
    input  logic                            i_item_ready,
    output msd_pkg::t_item                  o_item
);
    import msd_pkg::*;

    localparam logic [CNT_IN_W+1:0] MaxLines = (CNT_IN_W + 2)'(MAX_BAND_LINES);

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              accept;
    logic [WORD_W-1:0] atl;
    logic [WORD_W-1:0] atr;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] spr_min;

    assign o_ready      = !r_valid || i_item_ready;
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    assign atl     = (i_thr_left == '0) ? WORD_W'(1) : i_thr_left;
    assign atr     = (i_thr_right == '0) ? WORD_W'(1) : i_thr_right;
    assign m       = (atl < atr) ? atl : atr;
    assign spr_min = (i_spread_left < i_spread_right) ? i_spread_left : i_spread_right;

    always_comb begin
        n_item          = r_item;
        n_item.op       = i_opcode;
        n_item.m        = m;
        n_item.atl      = atl;
        n_item.atr      = atr;
        n_item.x        = (i_energy_left > atl) ? i_energy_left : atl;
        n_item.y        = (i_energy_right > atr) ? i_energy_right : atr;
        n_item.p        = (i_energy_mid > m) ? i_energy_mid : m;
        n_item.q        = (i_energy_side > m) ? i_energy_side : m;
        n_item.thr_l    = i_thr_left;
        n_item.thr_r    = i_thr_right;
        n_item.en_l     = i_energy_left;
        n_item.en_r     = i_energy_right;
        n_item.en_m     = i_energy_mid;
        n_item.en_s     = i_energy_side;
        n_item.spr_l    = i_spread_left;
        n_item.spr_r    = i_spread_right;
        n_item.thr_min  = (i_thr_left < i_thr_right) ? i_thr_left : i_thr_right;
        n_item.spr_half = spr_min >> 1;
        n_item.cnt      = ({2'b00, i_line_count} > MaxLines) ?
                          MaxLines[CNT_IN_W-1:0] : i_line_count;
        n_item.smp_l    = i_sample_left;
        n_item.smp_r    = i_sample_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            // drop unused codes here, they give no result
            r_valid <= (r_valid && !i_item_ready) || (accept && i_opcode != OP_UNUSED);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/core/msd_queue.sv]
// ----------------------------------------------------------------------------
// msd_queue: short request queue between front and back
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module msd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  msd_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output msd_pkg::t_item o_pop_item
);
    import msd_pkg::*;

    localparam int unsigned AW = $clog2(Q_DEPTH);
    localparam int unsigned CW = $clog2(Q_DEPTH + 1);

    t_item           r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

[rtl/core/msd_back.sv]
// ----------------------------------------------------------------------------
// msd_back: band decision sequencer, line conversion and frame report
// Two 32x32 multipliers build both 128-bit cross products ahead of the compare step.
// ----------------------------------------------------------------------------
module msd_back #(
    parameter int MAX_BAND_LINES = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_item_valid,
    output logic                             o_item_ready,
    input  msd_pkg::t_item                   i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [1:0]                       o_kind,
    output logic                             o_ms_used,
    output logic [msd_pkg::WORD_W-1:0]       o_out_thr_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_thr_right,
    output logic [msd_pkg::WORD_W-1:0]       o_out_energy_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_energy_right,
    output logic [msd_pkg::WORD_W-1:0]       o_out_spread_left,
    output logic [msd_pkg::WORD_W-1:0]       o_out_spread_right,
    output logic signed [msd_pkg::SMP_W-1:0] o_out_left,
    output logic signed [msd_pkg::SMP_W-1:0] o_out_right,
    output logic [1:0]                       o_ms_select
);
    import msd_pkg::*;

    localparam int unsigned CNT_W = (MAX_BAND_LINES < 2047) ?
                                    $clog2(MAX_BAND_LINES + 1) : CNT_IN_W;
    localparam int unsigned HW    = WORD_W;
    localparam int unsigned PW    = 2 * WORD_W;
    localparam int unsigned AW    = 4 * WORD_W;

    localparam logic [3:0] STEP_SQ    = 4'd0;
    localparam logic [3:0] STEP_PROD  = 4'd1;
    localparam logic [3:0] STEP_LATCH = 4'd2;
    localparam logic [3:0] STEP_PP0   = 4'd3;
    localparam logic [3:0] STEP_ACC0  = 4'd4;
    localparam logic [3:0] STEP_ACC3  = 4'd7;
    localparam logic [3:0] STEP_CMP   = 4'd8;

    typedef enum logic {S_RUN, S_BAND} t_state;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    ms_used;
        logic [WORD_W-1:0]       thr_l;
        logic [WORD_W-1:0]       thr_r;
        logic [WORD_W-1:0]       en_l;
        logic [WORD_W-1:0]       en_r;
        logic [WORD_W-1:0]       spr_l;
        logic [WORD_W-1:0]       spr_r;
        logic signed [SMP_W-1:0] smp_l;
        logic signed [SMP_W-1:0] smp_r;
        logic [1:0]              sel;
    } t_result;

    t_state           r_state;
    logic [3:0]       r_step;
    logic             r_o_valid;
    t_result          r_res;
    logic             r_band_is_ms;
    logic [CNT_W-1:0] r_lines_left;
    logic             r_any_ms;
    logic             r_any_lr;
    logic [PW-1:0]    r_pa;
    logic [PW-1:0]    r_pb;
    logic [PW-1:0]    r_ha;
    logic [PW-1:0]    r_hb;
    logic [PW-1:0]    r_ga;
    logic [PW-1:0]    r_gb;
    logic [AW-1:0]    r_acc_a;
    logic [AW-1:0]    r_acc_b;

    logic             out_free;
    logic             conv;
    logic             band_ms;
    logic [SMP_W:0]   sum;
    logic [SMP_W:0]   dif;
    logic [1:0]       k_issue;
    logic [1:0]       k_acc;
    logic [HW-1:0]    opa_a;
    logic [HW-1:0]    opa_b;
    logic [HW-1:0]    opb_a;
    logic [HW-1:0]    opb_b;
    logic [PW-1:0]    prod_a;
    logic [PW-1:0]    prod_b;
    logic [AW-1:0]    pp_a;
    logic [AW-1:0]    pp_b;
    t_result          res_line;
    t_result          res_frame;
    t_result          res_band;

    assign out_free = !r_o_valid || i_ready;
    assign conv     = (r_lines_left != '0) && r_band_is_ms;
    assign band_ms  = (r_acc_a >= r_acc_b);

    assign o_item_ready = (r_state == S_RUN && i_item_valid && i_item.op != OP_BAND && out_free)
                       || (r_state == S_BAND && r_step == STEP_CMP && out_free);

    // floor halving: drop the low bit of the 25-bit sum and difference
    assign sum = {i_item.smp_l[SMP_W-1], i_item.smp_l} + {i_item.smp_r[SMP_W-1], i_item.smp_r};
    assign dif = {i_item.smp_l[SMP_W-1], i_item.smp_l} - {i_item.smp_r[SMP_W-1], i_item.smp_r};

    assign k_issue = 2'(r_step - STEP_PP0);
    assign k_acc   = 2'(r_step - STEP_ACC0);

    always_comb begin
        opa_a = i_item.m;
        opa_b = i_item.m;
        opb_a = i_item.atl;
        opb_b = i_item.atr;
        case (r_step)
            STEP_SQ: begin
                opa_a = i_item.m;
                opa_b = i_item.m;
                opb_a = i_item.atl;
                opb_b = i_item.atr;
            end
            STEP_PROD: begin
                opa_a = i_item.x;
                opa_b = i_item.y;
                opb_a = i_item.p;
                opb_b = i_item.q;
            end
            default: begin
                // partial products of the two 64x64 products
                opa_a = k_issue[1] ? r_ha[PW-1:HW] : r_ha[HW-1:0];
                opa_b = k_issue[0] ? r_ga[PW-1:HW] : r_ga[HW-1:0];
                opb_a = k_issue[1] ? r_hb[PW-1:HW] : r_hb[HW-1:0];
                opb_b = k_issue[0] ? r_gb[PW-1:HW] : r_gb[HW-1:0];
            end
        endcase
    end

    assign prod_a = opa_a * opa_b;
    assign prod_b = opb_a * opb_b;

    always_comb begin
        case (k_acc)
            2'd0: begin
                pp_a = {{PW{1'b0}}, r_pa};
                pp_b = {{PW{1'b0}}, r_pb};
            end
            2'd3: begin
                pp_a = {r_pa, {PW{1'b0}}};
                pp_b = {r_pb, {PW{1'b0}}};
            end
            default: begin
                pp_a = {{HW{1'b0}}, r_pa, {HW{1'b0}}};
                pp_b = {{HW{1'b0}}, r_pb, {HW{1'b0}}};
            end
        endcase
    end

    always_comb begin
        res_line         = '0;
        res_line.kind    = KIND_LINE;
        res_line.ms_used = conv;
        res_line.smp_l   = conv ? sum[SMP_W:1] : i_item.smp_l;
        res_line.smp_r   = conv ? dif[SMP_W:1] : i_item.smp_r;

        res_frame      = '0;
        res_frame.kind = KIND_FRAME;
        if (r_any_ms) begin
            res_frame.sel = r_any_lr ? SEL_SOME : SEL_ALL;
        end else begin
            res_frame.sel = SEL_NONE;
        end

        res_band         = '0;
        res_band.kind    = KIND_BAND;
        res_band.ms_used = band_ms;
        if (band_ms) begin
            res_band.thr_l = i_item.thr_min;
            res_band.thr_r = i_item.thr_min;
            res_band.en_l  = i_item.en_m;
            res_band.en_r  = i_item.en_s;
            res_band.spr_l = i_item.spr_half;
            res_band.spr_r = i_item.spr_half;
        end else begin
            res_band.thr_l = i_item.thr_l;
            res_band.thr_r = i_item.thr_r;
            res_band.en_l  = i_item.en_l;
            res_band.en_r  = i_item.en_r;
            res_band.spr_l = i_item.spr_l;
            res_band.spr_r = i_item.spr_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_step       <= STEP_SQ;
            r_o_valid    <= 1'b0;
            r_band_is_ms <= 1'b0;
            r_lines_left <= '0;
            r_any_ms     <= 1'b0;
            r_any_lr     <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (i_item_valid && i_item.op == OP_BAND) begin
                        r_state <= S_BAND;
                        r_step  <= STEP_SQ;
                    end else if (o_item_ready) begin
                        r_o_valid <= 1'b1;
                        if (i_item.op == OP_LINE) begin
                            r_res <= res_line;
                            if (r_lines_left != '0) begin
                                r_lines_left <= r_lines_left - CNT_W'(1);
                            end
                        end else begin
                            r_res        <= res_frame;
                            r_band_is_ms <= 1'b0;
                            r_lines_left <= '0;
                            r_any_ms     <= 1'b0;
                            r_any_lr     <= 1'b0;
                        end
                    end
                end
                S_BAND: begin
                    if (r_step != STEP_CMP) begin
                        r_step <= r_step + 4'd1;
                    end else if (out_free) begin
                        // hold at compare until the output slot frees up
                        r_o_valid    <= 1'b1;
                        r_res        <= res_band;
                        r_band_is_ms <= band_ms;
                        r_lines_left <= i_item.cnt[CNT_W-1:0];
                        if (band_ms) begin
                            r_any_ms <= 1'b1;
                        end else begin
                            r_any_lr <= 1'b1;
                        end
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // multiplier datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_pa <= prod_a;
        r_pb <= prod_b;
        if (r_state == S_BAND) begin
            if (r_step == STEP_PROD) begin
                r_ha <= r_pa;
                r_hb <= r_pb;
            end
            if (r_step == STEP_LATCH) begin
                r_ga    <= r_pa;
                r_gb    <= r_pb;
                r_acc_a <= '0;
                r_acc_b <= '0;
            end
            if (r_step >= STEP_ACC0 && r_step <= STEP_ACC3) begin
                r_acc_a <= r_acc_a + pp_a;
                r_acc_b <= r_acc_b + pp_b;
            end
        end
    end

    assign o_valid            = r_o_valid;
    assign o_kind             = r_res.kind;
    assign o_ms_used          = r_res.ms_used;
    assign o_out_thr_left     = r_res.thr_l;
    assign o_out_thr_right    = r_res.thr_r;
    assign o_out_energy_left  = r_res.en_l;
    assign o_out_energy_right = r_res.en_r;
    assign o_out_spread_left  = r_res.spr_l;
    assign o_out_spread_right = r_res.spr_r;
    assign o_out_left         = r_res.smp_l;
    assign o_out_right        = r_res.smp_r;
    assign o_ms_select        = r_res.sel;

endmodule
